/* design/tcs_pkg.sv */
package tcs_pkg;

   typedef enum logic [1:0] {
      CMD_WAIT       = 2'd0,
      CMD_SIGNAL     = 2'd1,
      CMD_TICK       = 2'd2,
      CMD_SIGNAL_ALL = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ACQUIRED  = 3'd0,
      KIND_BLOCKED   = 3'd1,
      KIND_RELEASED  = 3'd2,
      KIND_TIMED_OUT = 3'd3,
      KIND_REJECTED  = 3'd4
   } kind_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] ticks;
   } entry_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         id;
      logic               acq;
      logic signed [15:0] count;
      logic               last;
   } rsp_type;

   localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;
   localparam logic signed [15:0] COUNT_MIN = 16'sh8000;

endpackage

/* design/timed_counting_semaphore_core.sv */
// Channel   Direction  Handshake          Transfer
// req_      in         valid / stall      cmd, thread_id, max_wait
// rsp_      out        valid / stall      kind, thread_id_out, acquired_flag, count_now, last
// csr_      in         valid / ready      initial_count (also loads the count)
//
// Wait: result registered on the accepting edge.
// Signal: the head entry of the waiter RAM is read before the result is registered in S_SIG.
// Signal all: S_SALL releases waiters one after another until the count or the queue runs out.
// Tick: one RAM read per entry (more while frozen); one write-back per unexpired entry.
// Reset clears count to 1 and empties the queue; no clearing pass.
// Output stall freezes the sequencer only where a result must move.
module timed_counting_semaphore_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_thread_id,
   input  logic [15:0]        req_max_wait,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_thread_id_out,
   output logic               rsp_acquired_flag,
   output logic signed [15:0] rsp_count_now,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_initial_count
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SIG,
      S_SALL,
      S_TICK
   } state_type;

   function automatic logic [PW-1:0] wrap_pos(input logic [PW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= (CW+1)'(QUEUE_DEPTH)) begin
         s = s - (CW+1)'(QUEUE_DEPTH);
      end
      return s[PW-1:0];
   endfunction

   function automatic tcs_pkg::rsp_type make_rsp(input tcs_pkg::kind_type kind,
                                                 input logic [7:0] id,
                                                 input logic acq,
                                                 input logic signed [15:0] cnt,
                                                 input logic last);
      tcs_pkg::rsp_type r;
      r.kind  = kind;
      r.id    = id;
      r.acq   = acq;
      r.count = cnt;
      r.last  = last;
      return r;
   endfunction

   state_type          state_ff;
   logic signed [15:0] count_ff;
   logic [PW-1:0]      head_ff;
   logic [CW-1:0]      wc_ff;
   logic [CW-1:0]      nrel_ff;
   logic [CW-1:0]      tk_pos_ff;
   logic [CW-1:0]      tk_w_ff;
   logic [CW-1:0]      tk_n_ff;
   logic               rsp_valid_ff;
   tcs_pkg::rsp_type   rsp_ff;
   logic               hold_valid_ff;
   tcs_pkg::rsp_type   hold_ff;

   logic                    out_free;
   logic                    req_accept;
   tcs_pkg::cmd_type        cmd;
   logic signed [15:0]      cnt_inc;
   logic signed [15:0]      cnt_dec;
   logic                    sig_release;
   logic                    tk_active;
   logic                    expire;
   logic                    freeze;
   logic [15:0]             keep_ticks;
   tcs_pkg::entry_type      rd_entry;
   tcs_pkg::entry_type      wr_entry;
   logic                    ram_wr_en;
   logic [PW-1:0]           ram_wr_addr;
   logic [PW-1:0]           ram_rd_addr;
   logic [$bits(tcs_pkg::entry_type)-1:0] ram_rd_data;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = !(state_ff == S_IDLE && out_free && !csr_valid);
   assign req_accept  = req_valid && !req_stall;
   assign csr_ready   = (state_ff == S_IDLE);
   assign cmd         = tcs_pkg::cmd_type'(req_cmd);

   assign cnt_inc = (count_ff == tcs_pkg::COUNT_MAX) ? count_ff : count_ff + 16'sd1;
   assign cnt_dec = (count_ff == tcs_pkg::COUNT_MIN) ? count_ff : count_ff - 16'sd1;

   assign sig_release = count_ff[15] && (wc_ff != '0);

   assign rd_entry   = tcs_pkg::entry_type'(ram_rd_data);
   assign tk_active  = (state_ff == S_TICK) && (tk_pos_ff < tk_n_ff);
   assign expire     = (rd_entry.ticks == 16'd1);
   assign freeze     = tk_active && expire && hold_valid_ff && !out_free;
   assign keep_ticks = (rd_entry.ticks == 16'd0) ? 16'd0 : rd_entry.ticks - 16'd1;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = wrap_pos(head_ff, wc_ff);
      wr_entry.id    = req_thread_id;
      wr_entry.ticks = req_max_wait;
      ram_rd_addr = head_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && cmd == tcs_pkg::CMD_WAIT && count_ff <= 16'sd0
                && wc_ff != CW'(QUEUE_DEPTH)) begin
               ram_wr_en = 1'b1;
            end
         end
         S_SIG, S_SALL: begin
            if (sig_release && out_free) begin
               ram_rd_addr = wrap_pos(head_ff, CW'(1));
            end
         end
         S_TICK: begin
            if (tk_active) begin
               if (freeze) begin
                  ram_rd_addr = wrap_pos(head_ff, tk_pos_ff);
               end else begin
                  ram_rd_addr = wrap_pos(head_ff, tk_pos_ff + CW'(1));
               end
               if (!expire) begin
                  ram_wr_en      = 1'b1;
                  ram_wr_addr    = wrap_pos(head_ff, tk_w_ff);
                  wr_entry.id    = rd_entry.id;
                  wr_entry.ticks = keep_ticks;
               end
            end
         end
         default: begin
            ram_rd_addr = head_ff;
         end
      endcase
   end

   tcs_ram #(
      .WIDTH ($bits(tcs_pkg::entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_waiter_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_entry),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= 16'sd1;
         head_ff       <= '0;
         wc_ff         <= '0;
         nrel_ff       <= '0;
         tk_pos_ff     <= '0;
         tk_w_ff       <= '0;
         tk_n_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (csr_valid) begin
                  count_ff <= signed'({8'd0, csr_initial_count});
               end else if (req_accept) begin
                  unique case (cmd)
                     tcs_pkg::CMD_WAIT: begin
                        rsp_valid_ff <= 1'b1;
                        if (count_ff > 16'sd0) begin
                           count_ff <= cnt_dec;
                           rsp_ff   <= make_rsp(tcs_pkg::KIND_ACQUIRED, req_thread_id,
                                                1'b1, cnt_dec, 1'b1);
                        end else if (wc_ff == CW'(QUEUE_DEPTH)) begin
                           rsp_ff   <= make_rsp(tcs_pkg::KIND_REJECTED, req_thread_id,
                                                1'b0, count_ff, 1'b1);
                        end else begin
                           wc_ff    <= wc_ff + CW'(1);
                           count_ff <= cnt_dec;
                           rsp_ff   <= make_rsp(tcs_pkg::KIND_BLOCKED, req_thread_id,
                                                1'b0, cnt_dec, 1'b1);
                        end
                     end
                     tcs_pkg::CMD_SIGNAL: begin
                        state_ff <= S_SIG;
                     end
                     tcs_pkg::CMD_TICK: begin
                        tk_pos_ff <= '0;
                        tk_w_ff   <= '0;
                        tk_n_ff   <= wc_ff;
                        state_ff  <= S_TICK;
                     end
                     tcs_pkg::CMD_SIGNAL_ALL: begin
                        nrel_ff  <= '0;
                        state_ff <= S_SALL;
                     end
                  endcase
               end
            end
            S_SIG: begin
               if (sig_release) begin
                  if (out_free) begin
                     count_ff     <= cnt_inc;
                     head_ff      <= wrap_pos(head_ff, CW'(1));
                     wc_ff        <= wc_ff - CW'(1);
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= make_rsp(tcs_pkg::KIND_RELEASED, rd_entry.id,
                                              1'b1, cnt_inc, 1'b1);
                     state_ff     <= S_IDLE;
                  end
               end else begin
                  count_ff <= cnt_inc;
                  state_ff <= S_IDLE;
               end
            end
            S_SALL: begin
               if (sig_release) begin
                  if (out_free) begin
                     count_ff     <= cnt_inc;
                     head_ff      <= wrap_pos(head_ff, CW'(1));
                     wc_ff        <= wc_ff - CW'(1);
                     nrel_ff      <= nrel_ff + CW'(1);
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= make_rsp(tcs_pkg::KIND_RELEASED, rd_entry.id, 1'b1,
                                              cnt_inc, !cnt_inc[15] || wc_ff == CW'(1));
                  end
               end else begin
                  // queue drained early: a negative count is raised to zero
                  if (count_ff[15] && nrel_ff != CW'(QUEUE_DEPTH)) begin
                     count_ff <= 16'sd0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_TICK: begin
               if (tk_active) begin
                  if (!freeze) begin
                     tk_pos_ff <= tk_pos_ff + CW'(1);
                     if (expire) begin
                        count_ff      <= cnt_inc;
                        hold_valid_ff <= 1'b1;
                        hold_ff       <= make_rsp(tcs_pkg::KIND_TIMED_OUT, rd_entry.id,
                                                  1'b0, cnt_inc, 1'b0);
                        if (hold_valid_ff) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff       <= hold_ff;
                        end
                     end else begin
                        tk_w_ff <= tk_w_ff + CW'(1);
                     end
                  end
               end else begin
                  wc_ff <= tk_w_ff;
                  if (!hold_valid_ff) begin
                     state_ff <= S_IDLE;
                  end else if (out_free) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_ff        <= make_rsp(hold_ff.kind, hold_ff.id, hold_ff.acq,
                                               hold_ff.count, 1'b1);
                     hold_valid_ff <= 1'b0;
                     state_ff      <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_ff.kind;
   assign rsp_thread_id_out = rsp_ff.id;
   assign rsp_acquired_flag = rsp_ff.acq;
   assign rsp_count_now     = rsp_ff.count;
   assign rsp_last          = rsp_ff.last;

`ifndef SYNTHESIS
   a_wc_bound: assert property (@(posedge clock) disable iff (reset)
      wc_ff <= CW'(QUEUE_DEPTH))
      else $error("waiter count beyond queue depth");

   a_compact_behind: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TICK |-> tk_w_ff <= tk_pos_ff && tk_pos_ff <= tk_n_ff)
      else $error("tick write-back overtook the read position");

   a_hold_in_tick: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_TICK |-> !hold_valid_ff)
      else $error("pending timeout result outside a tick");

   a_release_pops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SIG || state_ff == S_SALL) && sig_release && out_free
      |=> wc_ff == $past(wc_ff) - CW'(1))
      else $error("release did not remove a waiter");
`endif

endmodule

/* design/tcs_ram.sv */
module tcs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
